### rtl/egc_pkg.sv
// ----------------------------------------------------------------------------
// egc_pkg: shared definitions of the elevator group controller
// Field widths, event and car mode codes, and default parameter values.
// ----------------------------------------------------------------------------
package egc_pkg;

    localparam int FLOOR_W = 7;
    localparam int RIDER_W = 16;
    localparam int ENTRY_W = RIDER_W + FLOOR_W;
    localparam int MOVE_W  = 8;
    localparam int TICK_W  = 32;
    localparam int RES_W   = 3;
    localparam int CAR_W   = 3;

    localparam int FLOORS_DEF      = 100;
    localparam int CARS_DEF        = 2;
    localparam int CAPACITY_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [MOVE_W-1:0] MOVE_RESET  = 8'd10;
    localparam logic [1:0]        DWELL_TICKS = 2'd2;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    localparam logic [RES_W-1:0] EV_QUEUED    = 3'd0;
    localparam logic [RES_W-1:0] EV_DROPPED   = 3'd1;
    localparam logic [RES_W-1:0] EV_EXITED    = 3'd2;
    localparam logic [RES_W-1:0] EV_BOARDED   = 3'd3;
    localparam logic [RES_W-1:0] EV_TICK_DONE = 3'd4;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_STOPPING = 2'd1,
        MODE_UP       = 2'd2,
        MODE_DOWN     = 2'd3
    } car_mode_t;

endpackage

### rtl/elevator_group_controller.sv
// ----------------------------------------------------------------------------
// elevator_group_controller: group control of elevator cars
// Per-floor waiting queues and car rider lists held in block memories.
// ----------------------------------------------------------------------------
// Usage. The slave stream carries one transaction per command: s_tuser is the
// opcode (tick or arrival) and s_tdata the rider id, start floor and goal
// floor of an arrival. The master stream returns events: s_tuser-like kind
// code on m_tuser, car, rider, floor and tick count on m_tdata, and m_tlast
// on the final event caused by a command. cfg_wr_en/cfg_wr_data write the
// travel time per floor; write it only while the block is idle.
// An arrival's event passes through the S_ARR and S_EMIT states into the
// output register, and the next command can be accepted once it is loaded
// there. A tick visits each car in turn: a dwelling or counting car is
// handled at once, a car that steps a floor reads the new floor's queue
// and, if no one waits there, its rider list one entry a cycle, and a
// standing car lets riders exit, boards waiting riders and, when it is left
// empty, scans every floor for the nearest call, one floor read at a time.
// The completion event follows the last car; the tick count then advances.
// Commands are handled one at a time: s_tready is high only while the
// controller waits for a command.
// Reset clears all car state, the tick counter and the queue valid bits
// directly, so no clearing pass is needed. When the receiver stalls,
// the event stays in the output register and the controller waits with the
// next event until it is taken.
// ----------------------------------------------------------------------------
module elevator_group_controller #(
    parameter int FLOORS      = egc_pkg::FLOORS_DEF,
    parameter int CARS        = egc_pkg::CARS_DEF,
    parameter int CAPACITY    = egc_pkg::CAPACITY_DEF,
    parameter int QUEUE_DEPTH = egc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [egc_pkg::MOVE_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // s_tdata: rider_id[15:0], start_floor[22:16], goal_floor[29:23], zero fill
    input  logic [31:0]                s_tdata,
    // s_tuser: opcode[0]
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata: car_index[2:0], event_rider[18:3], event_floor[25:19],
    //          seconds[57:26], zero fill
    output logic [63:0]                m_tdata,
    // m_tuser: event_res[2:0]
    output logic [2:0]                 m_tuser,
    output logic                       m_tlast
);
    import egc_pkg::*;

    localparam int CIW   = (CARS > 1) ? $clog2(CARS) : 1;
    localparam int LW    = $clog2(CAPACITY + 1);
    localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int FAW   = $clog2(FLOORS + 1);
    localparam int RBASE = (FLOORS + 1) * QUEUE_DEPTH;
    localparam int SDEP  = RBASE + CARS * CAPACITY;
    localparam int SAW   = $clog2(SDEP);
    localparam int QW    = HW + CW;

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_ARR      = 17'h00002,
        S_CAR      = 17'h00004,
        S_TR_FQ    = 17'h00008,
        S_TR_RD    = 17'h00010,
        S_SV_ISSUE = 17'h00020,
        S_SV_DATA  = 17'h00040,
        S_BD_ISSUE = 17'h00080,
        S_BD_FQ    = 17'h00100,
        S_BD_DATA  = 17'h00200,
        S_TG_R0    = 17'h00400,
        S_SC_ISSUE = 17'h00800,
        S_SC_DATA  = 17'h01000,
        S_TG_SET   = 17'h02000,
        S_NEXT     = 17'h04000,
        S_TICK_END = 17'h08000,
        S_EMIT     = 17'h10000
    } state_t;

    // Shared store: waiting queue slots per floor, then rider lists per car.
    logic [ENTRY_W-1:0] store_mem [SDEP];
    logic               st_we;
    logic [SAW-1:0]     st_waddr, st_raddr;
    logic [ENTRY_W-1:0] st_wdata, st_rdata_reg;

    // Queue state per floor: {head, count}; valid bits give the reset value.
    logic [QW-1:0]  fq_mem [FLOORS + 1];
    logic           fq_we;
    logic [FAW-1:0] fq_waddr, fq_raddr;
    logic [QW-1:0]  fq_wdata, fq_rdata_reg;
    logic           fq_rvalid_reg;
    logic [FLOORS:0] fq_valid_reg, fq_valid_next;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [FLOOR_W-1:0] car_floor_reg [CARS];
    logic [FLOOR_W-1:0] car_floor_next [CARS];
    car_mode_t          car_mode_reg [CARS];
    car_mode_t          car_mode_next [CARS];
    logic [MOVE_W-1:0]  car_move_reg [CARS];
    logic [MOVE_W-1:0]  car_move_next [CARS];
    logic [1:0]         car_dwell_reg [CARS];
    logic [1:0]         car_dwell_next [CARS];
    logic [LW-1:0]      car_load_reg [CARS];
    logic [LW-1:0]      car_load_next [CARS];

    logic [MOVE_W-1:0]  mtpf_reg, mtpf_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [CIW-1:0]     c_reg, c_next;
    logic [LW-1:0]      i_reg, i_next, k_reg, k_next;
    logic [FLOOR_W:0]   g_reg, g_next, best_reg, best_next;
    logic [FLOOR_W-1:0] tgt_reg, tgt_next;
    logic [HW-1:0]      hd_reg, hd_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [RIDER_W-1:0] id_reg, id_next;
    logic [FLOOR_W-1:0] sf_reg, sf_next, gf_reg, gf_next;

    logic [RES_W-1:0]   ev_res_reg, ev_res_next;
    logic [CIW-1:0]     ev_car_reg, ev_car_next;
    logic [RIDER_W-1:0] ev_rider_reg, ev_rider_next;
    logic [FLOOR_W-1:0] ev_floor_reg, ev_floor_next;
    logic               ev_last_reg, ev_last_next;

    logic               m_valid_reg, m_valid_next;
    logic [RES_W-1:0]   o_res_reg, o_res_next;
    logic [CIW-1:0]     o_car_reg, o_car_next;
    logic [RIDER_W-1:0] o_rider_reg, o_rider_next;
    logic [FLOOR_W-1:0] o_floor_reg, o_floor_next;
    logic [TICK_W-1:0]  o_sec_reg, o_sec_next;
    logic               o_last_reg, o_last_next;

    logic [CW-1:0]      rd_cnt;
    logic [HW-1:0]      rd_head;
    logic [FLOOR_W-1:0] cur_floor, new_floor, e_floor;
    car_mode_t          cur_mode;
    logic [FLOOR_W-1:0] in_start, in_goal;
    logic               arr_ok;
    logic [HW:0]        slot_sum, hd_inc;
    logic [HW-1:0]      slot, hd_wrap;
    logic [FLOOR_W:0]   floor_gap;

    function automatic logic [SAW-1:0] rider_addr(input logic [CIW-1:0] c,
                                                   input logic [LW-1:0] i);
        return SAW'(RBASE) + SAW'(c) * SAW'(CAPACITY) + SAW'(i);
    endfunction

    function automatic logic [SAW-1:0] wait_addr(input logic [FLOOR_W-1:0] f,
                                                 input logic [HW-1:0] h);
        return SAW'(f) * SAW'(QUEUE_DEPTH) + SAW'(h);
    endfunction

    function automatic logic floor_ok(input logic [FLOOR_W-1:0] f);
        return (f != '0) && (f <= FLOOR_W'(FLOORS));
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_res_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {6'd0, o_sec_reg, o_floor_reg, o_rider_reg, CAR_W'(o_car_reg)};

    assign in_start = s_tdata[22:16];
    assign in_goal  = s_tdata[29:23];

    // A floor whose queue was never written reads as empty.
    assign rd_cnt  = fq_rvalid_reg ? fq_rdata_reg[CW-1:0] : '0;
    assign rd_head = fq_rvalid_reg ? fq_rdata_reg[QW-1:CW] : '0;

    assign cur_floor = car_floor_reg[c_reg];
    assign cur_mode  = car_mode_reg[c_reg];
    assign e_floor   = st_rdata_reg[FLOOR_W-1:0];
    assign arr_ok    = floor_ok(sf_reg) && floor_ok(gf_reg)
                       && (rd_cnt < CW'(QUEUE_DEPTH));

    assign slot_sum = {1'b0, rd_head} + (HW+1)'(rd_cnt);
    assign slot     = (slot_sum >= (HW+1)'(QUEUE_DEPTH))
                      ? HW'(slot_sum - (HW+1)'(QUEUE_DEPTH)) : slot_sum[HW-1:0];
    assign hd_inc   = {1'b0, hd_reg} + (HW+1)'(1);
    assign hd_wrap  = (hd_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : hd_inc[HW-1:0];
    assign floor_gap = (g_reg > {1'b0, cur_floor}) ? g_reg - {1'b0, cur_floor}
                                                   : {1'b0, cur_floor} - g_reg;

    always_comb begin
        if (cur_mode == MODE_UP) begin
            new_floor = (cur_floor < FLOOR_W'(FLOORS)) ? cur_floor + 1'b1 : cur_floor;
        end else begin
            new_floor = (cur_floor > FLOOR_W'(1)) ? cur_floor - 1'b1 : cur_floor;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        car_floor_next = car_floor_reg;
        car_mode_next  = car_mode_reg;
        car_move_next  = car_move_reg;
        car_dwell_next = car_dwell_reg;
        car_load_next  = car_load_reg;
        fq_valid_next  = fq_valid_reg;
        mtpf_next      = cfg_wr_en ? cfg_wr_data : mtpf_reg;
        tick_next      = tick_reg;
        c_next         = c_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        best_next      = best_reg;
        tgt_next       = tgt_reg;
        hd_next        = hd_reg;
        cnt_next       = cnt_reg;
        id_next        = id_reg;
        sf_next        = sf_reg;
        gf_next        = gf_reg;
        ev_res_next    = ev_res_reg;
        ev_car_next    = ev_car_reg;
        ev_rider_next  = ev_rider_reg;
        ev_floor_next  = ev_floor_reg;
        ev_last_next   = ev_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        o_res_next     = o_res_reg;
        o_car_next     = o_car_reg;
        o_rider_next   = o_rider_reg;
        o_floor_next   = o_floor_reg;
        o_sec_next     = o_sec_reg;
        o_last_next    = o_last_reg;
        st_we          = 1'b0;
        st_waddr       = '0;
        st_wdata       = st_rdata_reg;
        st_raddr       = '0;
        fq_we          = 1'b0;
        fq_waddr       = '0;
        fq_wdata       = '0;
        fq_raddr       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    id_next = s_tdata[15:0];
                    sf_next = in_start;
                    gf_next = in_goal;
                    if (s_tuser[0] == OP_ARRIVE) begin
                        fq_raddr   = floor_ok(in_start) ? FAW'(in_start) : '0;
                        state_next = S_ARR;
                    end else begin
                        c_next     = '0;
                        state_next = S_CAR;
                    end
                end
            end
            S_ARR: begin
                if (arr_ok) begin
                    st_we    = 1'b1;
                    st_waddr = wait_addr(sf_reg, slot);
                    st_wdata = {id_reg, gf_reg};
                    fq_we    = 1'b1;
                    fq_waddr = FAW'(sf_reg);
                    fq_wdata = {rd_head, rd_cnt + 1'b1};
                    fq_valid_next[FAW'(sf_reg)] = 1'b1;
                    ev_res_next = EV_QUEUED;
                end else begin
                    ev_res_next = EV_DROPPED;
                end
                ev_car_next   = '0;
                ev_rider_next = id_reg;
                ev_floor_next = sf_reg;
                ev_last_next  = 1'b1;
                ret_next      = S_IDLE;
                state_next    = S_EMIT;
            end
            S_CAR: begin
                case (cur_mode)
                    MODE_STOPPING: begin
                        if (car_dwell_reg[c_reg] <= 2'd1) begin
                            car_dwell_next[c_reg] = '0;
                            car_mode_next[c_reg]  = MODE_STOPPED;
                        end else begin
                            car_dwell_next[c_reg] = car_dwell_reg[c_reg] - 1'b1;
                        end
                        state_next = S_NEXT;
                    end
                    MODE_UP, MODE_DOWN: begin
                        if (car_move_reg[c_reg] > MOVE_W'(1)) begin
                            car_move_next[c_reg] = car_move_reg[c_reg] - 1'b1;
                            state_next = S_NEXT;
                        end else begin
                            car_move_next[c_reg]  = mtpf_reg;
                            car_floor_next[c_reg] = new_floor;
                            fq_raddr   = FAW'(new_floor);
                            state_next = S_TR_FQ;
                        end
                    end
                    default: begin
                        i_next     = '0;
                        k_next     = '0;
                        state_next = S_SV_ISSUE;
                    end
                endcase
            end
            S_TR_FQ, S_TR_RD: begin
                if ((state_reg == S_TR_FQ && rd_cnt != '0)
                    || (state_reg == S_TR_RD && e_floor == cur_floor)) begin
                    car_mode_next[c_reg]  = MODE_STOPPING;
                    car_dwell_next[c_reg] = DWELL_TICKS;
                    state_next = S_NEXT;
                end else if ((state_reg == S_TR_FQ && car_load_reg[c_reg] == '0)
                             || (state_reg == S_TR_RD && i_reg + 1'b1 == car_load_reg[c_reg]))
                begin
                    if (cur_mode == MODE_UP && cur_floor >= FLOOR_W'(FLOORS)) begin
                        car_mode_next[c_reg] = MODE_DOWN;
                    end else if (cur_mode == MODE_DOWN && cur_floor <= FLOOR_W'(1)) begin
                        car_mode_next[c_reg] = MODE_UP;
                    end
                    state_next = S_NEXT;
                end else begin
                    i_next     = (state_reg == S_TR_FQ) ? '0 : i_reg + 1'b1;
                    st_raddr   = rider_addr(c_reg, i_next);
                    state_next = S_TR_RD;
                end
            end
            S_SV_ISSUE: begin
                if (i_reg == car_load_reg[c_reg]) begin
                    state_next = S_BD_ISSUE;
                end else begin
                    st_raddr   = rider_addr(c_reg, i_reg);
                    state_next = S_SV_DATA;
                end
            end
            S_SV_DATA: begin
                i_next = i_reg + 1'b1;
                if (e_floor == cur_floor) begin
                    ev_res_next   = EV_EXITED;
                    ev_car_next   = c_reg;
                    ev_rider_next = st_rdata_reg[ENTRY_W-1:FLOOR_W];
                    ev_floor_next = cur_floor;
                    ev_last_next  = 1'b0;
                    ret_next      = S_SV_ISSUE;
                    state_next    = S_EMIT;
                end else begin
                    // Kept riders move down over the gaps left by those who exit.
                    st_we      = 1'b1;
                    st_waddr   = rider_addr(c_reg, k_reg);
                    k_next     = k_reg + 1'b1;
                    state_next = S_SV_ISSUE;
                end
            end
            S_BD_ISSUE: begin
                fq_raddr   = FAW'(cur_floor);
                state_next = S_BD_FQ;
            end
            S_BD_FQ: begin
                if (k_reg < LW'(CAPACITY) && rd_cnt != '0) begin
                    hd_next    = rd_head;
                    cnt_next   = rd_cnt;
                    st_raddr   = wait_addr(cur_floor, rd_head);
                    state_next = S_BD_DATA;
                end else if (k_reg != '0) begin
                    st_raddr   = rider_addr(c_reg, '0);
                    state_next = S_TG_R0;
                end else begin
                    g_next     = (FLOOR_W+1)'(1);
                    best_next  = (FLOOR_W+1)'(FLOORS + 1);
                    tgt_next   = '0;
                    state_next = S_SC_ISSUE;
                end
            end
            S_BD_DATA: begin
                st_we         = 1'b1;
                st_waddr      = rider_addr(c_reg, k_reg);
                k_next        = k_reg + 1'b1;
                fq_we         = 1'b1;
                fq_waddr      = FAW'(cur_floor);
                fq_wdata      = {hd_wrap, cnt_reg - 1'b1};
                ev_res_next   = EV_BOARDED;
                ev_car_next   = c_reg;
                ev_rider_next = st_rdata_reg[ENTRY_W-1:FLOOR_W];
                ev_floor_next = cur_floor;
                ev_last_next  = 1'b0;
                ret_next      = S_BD_ISSUE;
                state_next    = S_EMIT;
            end
            S_TG_R0: begin
                tgt_next   = e_floor;
                state_next = S_TG_SET;
            end
            S_SC_ISSUE: begin
                fq_raddr   = FAW'(g_reg);
                state_next = S_SC_DATA;
            end
            S_SC_DATA: begin
                // Strictly closer only, so the lowest floor wins a tie.
                if (rd_cnt != '0 && floor_gap < best_reg) begin
                    best_next = floor_gap;
                    tgt_next  = g_reg[FLOOR_W-1:0];
                end
                if (g_reg == (FLOOR_W+1)'(FLOORS)) begin
                    state_next = S_TG_SET;
                end else begin
                    g_next     = g_reg + 1'b1;
                    state_next = S_SC_ISSUE;
                end
            end
            S_TG_SET: begin
                car_load_next[c_reg] = k_reg;
                if (tgt_reg != '0) begin
                    car_mode_next[c_reg] = (tgt_reg > cur_floor) ? MODE_UP : MODE_DOWN;
                    car_move_next[c_reg] = mtpf_reg;
                end
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (c_reg == CIW'(CARS - 1)) begin
                    ev_res_next   = EV_TICK_DONE;
                    ev_car_next   = '0;
                    ev_rider_next = '0;
                    ev_floor_next = '0;
                    ev_last_next  = 1'b1;
                    ret_next      = S_TICK_END;
                    state_next    = S_EMIT;
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_CAR;
                end
            end
            S_TICK_END: begin
                tick_next  = tick_reg + 1'b1;
                state_next = S_IDLE;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    o_res_next   = ev_res_reg;
                    o_car_next   = ev_car_reg;
                    o_rider_next = ev_rider_reg;
                    o_floor_next = ev_floor_reg;
                    o_sec_next   = tick_reg;
                    o_last_next  = ev_last_reg;
                    state_next   = ret_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= store_mem[st_raddr];
        if (fq_we) begin
            fq_mem[fq_waddr] <= fq_wdata;
        end
        fq_rdata_reg  <= fq_mem[fq_raddr];
        fq_rvalid_reg <= fq_valid_reg[fq_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            fq_valid_reg <= '0;
            mtpf_reg     <= MOVE_RESET;
            tick_reg     <= '0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < CARS; c++) begin
                car_floor_reg[c] <= FLOOR_W'(1);
                car_mode_reg[c]  <= MODE_STOPPED;
                car_move_reg[c]  <= MOVE_RESET;
                car_dwell_reg[c] <= '0;
                car_load_reg[c]  <= '0;
            end
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fq_valid_reg  <= fq_valid_next;
            mtpf_reg      <= mtpf_next;
            tick_reg      <= tick_next;
            m_valid_reg   <= m_valid_next;
            car_floor_reg <= car_floor_next;
            car_mode_reg  <= car_mode_next;
            car_move_reg  <= car_move_next;
            car_dwell_reg <= car_dwell_next;
            car_load_reg  <= car_load_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg        <= c_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        g_reg        <= g_next;
        best_reg     <= best_next;
        tgt_reg      <= tgt_next;
        hd_reg       <= hd_next;
        cnt_reg      <= cnt_next;
        id_reg       <= id_next;
        sf_reg       <= sf_next;
        gf_reg       <= gf_next;
        ev_res_reg   <= ev_res_next;
        ev_car_reg   <= ev_car_next;
        ev_rider_reg <= ev_rider_next;
        ev_floor_reg <= ev_floor_next;
        ev_last_reg  <= ev_last_next;
        o_res_reg    <= o_res_next;
        o_car_reg    <= o_car_next;
        o_rider_reg  <= o_rider_next;
        o_floor_reg  <= o_floor_next;
        o_sec_reg    <= o_sec_next;
        o_last_reg   <= o_last_next;
    end

endmodule

### rtl/egc_checker.sv
// ----------------------------------------------------------------------------
// egc_checker: port checks of the elevator group controller
// Event framing on the result stream and output behaviour across reset.
// ----------------------------------------------------------------------------
module egc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import egc_pkg::*;

    // No event is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled event keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Arrival answers and tick completion close their command.
    a_closing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_QUEUED || m_tuser == EV_DROPPED
        || m_tuser == EV_TICK_DONE) |-> m_tlast)
        else $error("closing event without tlast");

    // Exit and board events are not last: the tick completion always follows them.
    a_inner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_EXITED || m_tuser == EV_BOARDED) |-> !m_tlast)
        else $error("rider event marked last");

endmodule

bind elevator_group_controller egc_checker u_egc_checker (.*);
